[design/efe_pkg.sv]
`default_nettype none

package efe_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 11;
	localparam int CRC_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int MAX_PAYLOAD = 1024;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int SUB_W       = 3;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
	localparam logic [SUB_W-1:0]  HDR_LAST  = 3'd6;

	localparam logic [CRC_W-1:0]  RST_CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0]  RST_CRC_INIT = 16'hFFFF;
	localparam logic [BYTE_W-1:0] RST_ESCAPE   = 8'hFE;
	localparam logic [BYTE_W-1:0] RST_CODE_FF  = 8'h01;
	localparam logic [BYTE_W-1:0] RST_CODE_ESC = 8'h02;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRC_POLY = 3'd0,
		REG_CRC_INIT = 3'd1,
		REG_ESCAPE   = 3'd2,
		REG_CODE_FF  = 3'd3,
		REG_CODE_ESC = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_PAYLOAD = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		K_START,
		K_DATA,
		K_ERROR,
		K_FIN
	} cmd_kind_t;

	typedef struct packed {
		logic              opcode;
		logic [BYTE_W-1:0] frame_type;
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_end;
		logic              frame_end;
		logic [CRC_W-1:0]  frame_crc;
		logic              error_flag;
	} rsp_t;

	typedef struct packed {
		logic [CRC_W-1:0]  crc_polynomial;
		logic [CRC_W-1:0]  crc_initial;
		logic [BYTE_W-1:0] escape_value;
		logic [BYTE_W-1:0] code_for_ff;
		logic [BYTE_W-1:0] code_for_escape;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] value;
		logic [LEN_W-1:0]  len;
		logic              flag;
		logic [CRC_W-1:0]  crc;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

[design/efe_front.sv]
`default_nettype none

module efe_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire efe_pkg::req_t req,
	input  wire efe_pkg::cfg_t cfg,
	input  wire efe_pkg::q_stat_t q_stat,
	output logic               push,
	output efe_pkg::cmd_t      push_cmd
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_FEED,
		F_FIN
	} fstate_t;

	fstate_t                              state_q;
	logic [1:0]                           cnt_q;
	logic [efe_pkg::CRC_W-1:0]            crc_q;
	logic [efe_pkg::LEN_W-1:0]            left_q;
	logic [efe_pkg::LEN_W-1:0]            len_q;
	logic                                 open_q;

	logic [efe_pkg::LEN_W-1:0]            len_sat;
	logic [efe_pkg::CRC_W-1:0]            crc_payload;
	logic [efe_pkg::BYTE_W-1:0]           feed_byte;
	logic                                 data_last;
	logic                                 acc;

	function automatic logic [efe_pkg::CRC_W-1:0] crc_feed(
		input logic [efe_pkg::CRC_W-1:0]  c_in,
		input logic [efe_pkg::BYTE_W-1:0] b,
		input logic [efe_pkg::CRC_W-1:0]  poly
	);
		logic [efe_pkg::CRC_W-1:0] c;
		c = c_in ^ {b, {(efe_pkg::CRC_W - efe_pkg::BYTE_W){1'b0}}};
		for (int k = 0; k < efe_pkg::BYTE_W; k++) begin
			if (c[efe_pkg::CRC_W-1]) begin
				c = {c[efe_pkg::CRC_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[efe_pkg::CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	assign len_sat = (req.payload_length > efe_pkg::LEN_W'(efe_pkg::MAX_PAYLOAD))
		? efe_pkg::LEN_W'(efe_pkg::MAX_PAYLOAD) : req.payload_length;
	assign crc_payload = crc_feed(crc_q, req.data_byte, cfg.crc_polynomial);
	assign data_last = (left_q <= efe_pkg::LEN_W'(1));
	assign req_ready = (state_q == F_IDLE) && !q_stat.full;
	assign acc       = req_valid && req_ready;

	always_comb begin
		case (cnt_q)
			2'd2:    feed_byte = efe_pkg::BYTE_W'(len_q >> efe_pkg::BYTE_W);
			2'd3:    feed_byte = len_q[efe_pkg::BYTE_W-1:0];
			default: feed_byte = efe_pkg::ZERO_BYTE;
		endcase
	end

	always_comb begin
		push_cmd = '0;
		if (state_q == F_FIN) begin
			push_cmd.kind = efe_pkg::K_FIN;
			push_cmd.crc  = crc_q;
		end else if (req.opcode == efe_pkg::OP_START) begin
			push_cmd.kind  = efe_pkg::K_START;
			push_cmd.value = req.frame_type;
			push_cmd.len   = len_sat;
			push_cmd.flag  = (len_sat == '0);
		end else if (open_q) begin
			push_cmd.kind  = efe_pkg::K_DATA;
			push_cmd.value = req.data_byte;
			push_cmd.flag  = data_last;
			push_cmd.crc   = crc_payload;
		end else begin
			push_cmd.kind = efe_pkg::K_ERROR;
		end
		push = acc || ((state_q == F_FIN) && !q_stat.full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			crc_q   <= efe_pkg::RST_CRC_INIT;
			left_q  <= '0;
			len_q   <= '0;
			open_q  <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (acc) begin
						if (req.opcode == efe_pkg::OP_START) begin
							crc_q   <= crc_feed(cfg.crc_initial, req.frame_type,
								cfg.crc_polynomial);
							len_q   <= len_sat;
							left_q  <= len_sat;
							open_q  <= 1'b1;
							cnt_q   <= '0;
							state_q <= F_FEED;
						end else if (open_q) begin
							crc_q <= crc_payload;
							if (data_last) begin
								open_q <= 1'b0;
								left_q <= '0;
							end else begin
								left_q <= left_q - efe_pkg::LEN_W'(1);
							end
						end
					end
				end
				F_FEED: begin
					crc_q <= crc_feed(crc_q, feed_byte, cfg.crc_polynomial);
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= (len_q == '0) ? F_FIN : F_IDLE;
					end
				end
				F_FIN: begin
					if (!q_stat.full) begin
						open_q  <= 1'b0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_feed_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_FEED) |-> open_q)
		else $error("header feed running with no frame open");
`endif

endmodule

`default_nettype wire

[design/efe_queue.sv]
`default_nettype none

module efe_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire efe_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output efe_pkg::cmd_t      head,
	output efe_pkg::q_stat_t   q_stat
);

	efe_pkg::cmd_t                  mem_q [efe_pkg::QUEUE_DEPTH];
	logic [efe_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [efe_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [efe_pkg::QCNT_W-1:0]     cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == efe_pkg::QCNT_W'(efe_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == efe_pkg::QPTR_W'(efe_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + efe_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == efe_pkg::QPTR_W'(efe_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + efe_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + efe_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - efe_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full && !pop))
		else $error("request pushed into a full queue");
`endif

endmodule

`default_nettype wire

[design/efe_back.sv]
`default_nettype none

module efe_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire efe_pkg::cmd_t    head,
	input  wire efe_pkg::q_stat_t q_stat,
	input  wire efe_pkg::cfg_t    cfg,
	output logic                  pop,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output efe_pkg::rsp_t         rsp
);

	typedef enum logic [1:0] {
		P_BODY,
		P_CRCH,
		P_CRCL
	} part_t;

	part_t                          part_q;
	logic [efe_pkg::SUB_W-1:0]      sub_q;
	logic                           rsp_valid_q;
	efe_pkg::rsp_t                  rsp_q;

	part_t                          eff;
	logic                           advance;
	logic [efe_pkg::BYTE_W-1:0]     src;
	logic                           is_ff;
	logic                           is_esc;
	logic                           two;
	logic [efe_pkg::BYTE_W-1:0]     byte_n;
	logic                           part_last;
	logic                           cmd_done;
	efe_pkg::rsp_t                  rsp_n;

	assign advance = !q_stat.empty && (!rsp_valid_q || rsp_ready);
	assign eff     = ((head.kind == efe_pkg::K_FIN) && (part_q == P_BODY)) ? P_CRCH : part_q;

	always_comb begin
		case (eff)
			P_CRCH:  src = head.crc[efe_pkg::CRC_W-1 -: efe_pkg::BYTE_W];
			P_CRCL:  src = head.crc[efe_pkg::BYTE_W-1:0];
			default: src = head.value;
		endcase
		is_ff  = (src == efe_pkg::SYNC_BYTE);
		is_esc = (src == cfg.escape_value);
		two    = is_ff || is_esc;

		if ((eff == P_BODY) && (head.kind == efe_pkg::K_START)) begin
			case (sub_q)
				3'd0, 3'd1: byte_n = efe_pkg::SYNC_BYTE;
				3'd2:       byte_n = head.value;
				3'd5:       byte_n = efe_pkg::BYTE_W'(head.len >> efe_pkg::BYTE_W);
				3'd6:       byte_n = head.len[efe_pkg::BYTE_W-1:0];
				default:    byte_n = efe_pkg::ZERO_BYTE;
			endcase
			part_last = (sub_q == efe_pkg::HDR_LAST);
		end else if ((eff == P_BODY) && (head.kind == efe_pkg::K_ERROR)) begin
			byte_n    = efe_pkg::ZERO_BYTE;
			part_last = 1'b1;
		end else if (sub_q == '0) begin
			byte_n    = two ? cfg.escape_value : src;
			part_last = !two;
		end else begin
			byte_n    = is_ff ? cfg.code_for_ff : cfg.code_for_escape;
			part_last = 1'b1;
		end

		cmd_done = part_last && ((eff == P_CRCL) ||
			((eff == P_BODY) && !((head.kind == efe_pkg::K_DATA) && head.flag)));

		rsp_n            = '0;
		rsp_n.out_byte   = byte_n;
		rsp_n.run_end    = cmd_done && !((head.kind == efe_pkg::K_START) && head.flag);
		rsp_n.frame_end  = cmd_done && (eff == P_CRCL);
		rsp_n.frame_crc  = (cmd_done && (eff == P_CRCL)) ? head.crc : '0;
		rsp_n.error_flag = (head.kind == efe_pkg::K_ERROR);
	end

	assign pop       = advance && cmd_done;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q      <= P_BODY;
			sub_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (advance) begin
				rsp_q       <= rsp_n;
				rsp_valid_q <= 1'b1;
				if (cmd_done) begin
					part_q <= P_BODY;
					sub_q  <= '0;
				end else if (part_last) begin
					part_q <= (eff == P_BODY) ? P_CRCH : P_CRCL;
					sub_q  <= '0;
				end else begin
					sub_q <= sub_q + efe_pkg::SUB_W'(1);
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_frame_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.frame_end) |-> rsp.run_end)
		else $error("frame closed without ending the run");
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error_flag) |->
			(rsp.run_end && !rsp.frame_end && (rsp.out_byte == efe_pkg::ZERO_BYTE)))
		else $error("error result carries frame data");
	a_crc_part_held: assert property (@(posedge clk) disable iff (!arst_n)
		(part_q != P_BODY) |-> !q_stat.empty)
		else $error("crc emission with no request at queue head");
`endif

endmodule

`default_nettype wire

[design/escaped_frame_encoder_core.sv]
// An accepted request is written into the queue; its wire bytes then go to the output register.
// Start request: crc fed type, zero, zero, length bytes, one per cycle; 7 header bytes out.
// Payload request: accepted every cycle while idle and the 2-entry queue has room; output is
// one wire byte per cycle when rsp_ready allows; 1-2 per payload byte (up to 6 on the last).
// Reset: configuration to defaults, no frame open, queue and output register empty.
`default_nettype none

module escaped_frame_encoder_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire efe_pkg::req_t                   req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output efe_pkg::rsp_t                        rsp,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [efe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [efe_pkg::CFG_DATA_W-1:0]  cfg_data
);

	efe_pkg::cfg_t    cfg_q;
	efe_pkg::cmd_t    push_cmd;
	efe_pkg::cmd_t    head;
	efe_pkg::q_stat_t q_stat;
	logic             push;
	logic             pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_polynomial  <= efe_pkg::RST_CRC_POLY;
			cfg_q.crc_initial     <= efe_pkg::RST_CRC_INIT;
			cfg_q.escape_value    <= efe_pkg::RST_ESCAPE;
			cfg_q.code_for_ff     <= efe_pkg::RST_CODE_FF;
			cfg_q.code_for_escape <= efe_pkg::RST_CODE_ESC;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				efe_pkg::REG_CRC_POLY: cfg_q.crc_polynomial  <= cfg_data;
				efe_pkg::REG_CRC_INIT: cfg_q.crc_initial     <= cfg_data;
				efe_pkg::REG_ESCAPE:   cfg_q.escape_value    <= cfg_data[efe_pkg::BYTE_W-1:0];
				efe_pkg::REG_CODE_FF:  cfg_q.code_for_ff     <= cfg_data[efe_pkg::BYTE_W-1:0];
				efe_pkg::REG_CODE_ESC: cfg_q.code_for_escape <= cfg_data[efe_pkg::BYTE_W-1:0];
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	efe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	efe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	efe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.cfg       (cfg_q),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[tb/tb_escaped_frame_encoder_core.sv]
`timescale 1ns / 1ps

class frame_byte_book;
	efe_pkg::cfg_t regs;
	logic [15:0]   crc_acc;
	logic [10:0]   bytes_left;
	bit            frame_open;
	efe_pkg::rsp_t expected_bytes[$];
	efe_pkg::rsp_t burst[$];
	int            errors;
	int            requests;
	int            bytes_checked;
	int            frames_closed;
	int            error_results;

	function new();
		regs.crc_polynomial  = efe_pkg::RST_CRC_POLY;
		regs.crc_initial     = efe_pkg::RST_CRC_INIT;
		regs.escape_value    = efe_pkg::RST_ESCAPE;
		regs.code_for_ff     = efe_pkg::RST_CODE_FF;
		regs.code_for_escape = efe_pkg::RST_CODE_ESC;
		crc_acc    = efe_pkg::RST_CRC_INIT;
		bytes_left = '0;
		frame_open = 1'b0;
	endfunction

	function void set_register(efe_pkg::cfg_reg_t idx, logic [15:0] v);
		case (idx)
			efe_pkg::REG_CRC_POLY: regs.crc_polynomial  = v;
			efe_pkg::REG_CRC_INIT: regs.crc_initial     = v;
			efe_pkg::REG_ESCAPE:   regs.escape_value    = v[7:0];
			efe_pkg::REG_CODE_FF:  regs.code_for_ff     = v[7:0];
			efe_pkg::REG_CODE_ESC: regs.code_for_escape = v[7:0];
			default: ;
		endcase
	endfunction

	function void feed(logic [7:0] b);
		logic [15:0] c;
		c = crc_acc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ regs.crc_polynomial) : (c << 1);
		crc_acc = c;
	endfunction

	function void push_byte(logic [7:0] b);
		efe_pkg::rsp_t r;
		r = '0;
		r.out_byte = b;
		burst.push_back(r);
	endfunction

	function void push_escaped(logic [7:0] b);
		if (b == 8'hFF) begin
			push_byte(regs.escape_value);
			push_byte(regs.code_for_ff);
		end else if (b == regs.escape_value) begin
			push_byte(regs.escape_value);
			push_byte(regs.code_for_escape);
		end else begin
			push_byte(b);
		end
	endfunction

	function void close_frame();
		efe_pkg::rsp_t last;
		push_escaped(crc_acc[15:8]);
		push_escaped(crc_acc[7:0]);
		last = burst.pop_back();
		last.frame_end = 1'b1;
		last.frame_crc = crc_acc;
		burst.push_back(last);
		frame_open = 1'b0;
		bytes_left = '0;
		frames_closed++;
	endfunction

	function void add_wire_bytes(efe_pkg::req_t r);
		efe_pkg::rsp_t last;
		logic [10:0]   len;
		burst.delete();
		requests++;
		if (r.opcode == efe_pkg::OP_START) begin
			len = r.payload_length;
			if (len > efe_pkg::MAX_PAYLOAD)
				len = 11'(efe_pkg::MAX_PAYLOAD);
			push_byte(efe_pkg::SYNC_BYTE);
			push_byte(efe_pkg::SYNC_BYTE);
			push_byte(r.frame_type);
			push_byte(efe_pkg::ZERO_BYTE);
			push_byte(efe_pkg::ZERO_BYTE);
			push_byte({5'b0, len[10:8]});
			push_byte(len[7:0]);
			crc_acc = regs.crc_initial;
			feed(r.frame_type);
			feed(efe_pkg::ZERO_BYTE);
			feed(efe_pkg::ZERO_BYTE);
			feed({5'b0, len[10:8]});
			feed(len[7:0]);
			frame_open = 1'b1;
			bytes_left = len;
			if (len == 0)
				close_frame();
		end else if (!frame_open) begin
			last = '0;
			last.error_flag = 1'b1;
			burst.push_back(last);
			error_results++;
		end else begin
			feed(r.data_byte);
			push_escaped(r.data_byte);
			if (bytes_left > 0)
				bytes_left = bytes_left - 1'b1;
			if (bytes_left == 0)
				close_frame();
		end
		last = burst.pop_back();
		last.run_end = 1'b1;
		burst.push_back(last);
		foreach (burst[i])
			expected_bytes.push_back(burst[i]);
	endfunction

	function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			if (errors <= 30)
				$display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
		end
	endfunction

	function void check_wire_byte(efe_pkg::rsp_t got);
		efe_pkg::rsp_t want;
		if (expected_bytes.size() == 0) begin
			errors++;
			if (errors <= 30)
				$display("%0t: wire byte with none expected, actual %h", $time, got);
			return;
		end
		want = expected_bytes.pop_front();
		bytes_checked++;
		compare_field("out_byte", want.out_byte, got.out_byte);
		compare_field("run_end", want.run_end, got.run_end);
		compare_field("frame_end", want.frame_end, got.frame_end);
		compare_field("frame_crc", want.frame_crc, got.frame_crc);
		compare_field("error_flag", want.error_flag, got.error_flag);
	endfunction
endclass

module tb_escaped_frame_encoder_core;
	localparam int LONG_HOLD    = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 40;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           rsp_ready = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic [efe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [efe_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	efe_pkg::req_t                  req       = '0;
	efe_pkg::rsp_t                  rsp;
	logic                           req_ready;
	logic                           rsp_valid;
	logic                           cfg_ready;

	int   idle_pct        = 0;
	int   stall_pct       = 0;
	int   frame_bytes_due = 0;
	logic holding         = 1'b0;
	event hold_off;

	frame_byte_book book = new();

	escaped_frame_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			book.check_wire_byte(rsp);
		if (holding)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial forever begin
		@(hold_off);
		holding <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		holding <= 1'b0;
	end

	function automatic efe_pkg::req_t make_start(logic [7:0] t, logic [10:0] len);
		efe_pkg::req_t r;
		r.opcode         = efe_pkg::OP_START;
		r.frame_type     = t;
		r.payload_length = len;
		r.data_byte      = 8'($urandom);
		return r;
	endfunction

	function automatic efe_pkg::req_t make_payload(logic [7:0] d);
		efe_pkg::req_t r;
		r.opcode         = efe_pkg::OP_PAYLOAD;
		r.frame_type     = 8'($urandom);
		r.payload_length = 11'($urandom);
		r.data_byte      = d;
		return r;
	endfunction

	function automatic logic [7:0] pick_data_byte();
		case ($urandom_range(5))
			0: return 8'hFF;
			1: return book.regs.escape_value;
			2: return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_request(input efe_pkg::req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		book.add_wire_bytes(r);
		if (r.opcode == efe_pkg::OP_START)
			frame_bytes_due = (r.payload_length > efe_pkg::MAX_PAYLOAD)
				? efe_pkg::MAX_PAYLOAD : r.payload_length;
		else if (frame_bytes_due > 0)
			frame_bytes_due--;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (book.expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input efe_pkg::cfg_reg_t idx, input logic [15:0] v);
		cfg_index <= idx;
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		book.set_register(idx, v);
	endtask

	task automatic configure(input logic [15:0] poly, input logic [15:0] init,
		input logic [7:0] esc, input logic [7:0] code_ff, input logic [7:0] code_esc);
		write_register(efe_pkg::REG_CRC_POLY, poly);
		write_register(efe_pkg::REG_CRC_INIT, init);
		write_register(efe_pkg::REG_ESCAPE, {8'h00, esc});
		write_register(efe_pkg::REG_CODE_FF, {8'h00, code_ff});
		write_register(efe_pkg::REG_CODE_ESC, {8'h00, code_esc});
		cfg_valid <= 1'b0;
	endtask

	task automatic random_traffic(input int count);
		int roll;
		repeat (count) begin
			roll = $urandom_range(99);
			if (frame_bytes_due > 0 && roll < 90)
				send_request(make_payload(pick_data_byte()));
			else if (frame_bytes_due == 0 && roll < 10)
				send_request(make_payload(8'($urandom)));
			else
				send_request(make_start(8'($urandom),
					11'($urandom_range(0, (roll >= 95) ? 40 : 6))));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_payload(8'hFF));
		send_request(make_start(8'h00, 11'd0));
		send_request(make_start(8'hFF, 11'd3));
		send_request(make_payload(8'hFF));
		send_request(make_payload(efe_pkg::RST_ESCAPE));
		send_request(make_payload(8'h00));
		send_request(make_start(8'hA5, 11'h7FF));
		send_request(make_payload(8'h7E));
		send_request(make_start(8'h3C, 11'd1024));
		send_request(make_start(8'h5A, 11'd2));
		send_request(make_payload(8'hFE));
		send_request(make_payload(8'hFF));
		send_request(make_payload(8'h11));
		random_traffic(PHASE_ITEMS);
		wait_drained();

		configure(16'h0000, 16'h0000, 8'h00, 8'hFF, 8'hFF);
		idle_pct = 50;
		random_traffic(PHASE_ITEMS);
		wait_drained();

		configure(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 8'h00);
		idle_pct  = 0;
		stall_pct = 50;
		random_traffic(PHASE_ITEMS);
		wait_drained();
		stall_pct = 0;
		-> hold_off;
		random_traffic(30);
		wait_drained();

		configure(16'h8005, 16'h1D0F, 8'h7D, 8'h5E, 8'h5D);
		idle_pct  = 16;
		stall_pct = 16;
		random_traffic(PHASE_ITEMS);
		send_request(make_start(8'hC3, 11'd20));
		while (frame_bytes_due > 0)
			send_request(make_payload(pick_data_byte()));
		random_traffic(PHASE_ITEMS);
		wait_drained();

		configure(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		idle_pct  = 0;
		stall_pct = 0;
		random_traffic(PHASE_ITEMS);
		wait_drained();

		$display("Run covered %0d requests, %0d wire bytes, %0d closed frames, %0d stray payloads",
			book.requests, book.bytes_checked, book.frames_closed, book.error_results);
		$display("Five register settings incl. all-zero/all-ones, idle and stall mixes, output hold-off");
		if (book.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
